>>> sv/lfts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfts_pkg
// Shared types, codes and constants of the line follower turn sequencer.
// ----------------------------------------------------------------------------
package lfts_pkg;

	localparam int YAW_W    = 16;
	localparam int TIME_W   = 32;
	localparam int ANGLE_W  = 9;
	localparam int PERIOD_W = 20;
	localparam int PROD_W   = 36;  // signed yaw * unsigned period always fits
	localparam int THR_W    = 33;  // 360 deg * 16e6 fits in 33 bits
	localparam int HEAD_W   = 64;
	localparam int PWR_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [THR_W-1:0] HEADING_PER_DEG = THR_W'(16000000);

	localparam logic [ANGLE_W-1:0]  TURN_ANGLE_RST       = ANGLE_W'(72);
	localparam logic [ANGLE_W-1:0]  TURNAROUND_ANGLE_RST = ANGLE_W'(140);
	localparam logic [PERIOD_W-1:0] PERIOD_RST           = PERIOD_W'(10000);

	localparam logic signed [PWR_W-1:0] PWR_ZERO = PWR_W'(0);
	localparam logic signed [PWR_W-1:0] PWR_FWD  = PWR_W'(60);
	localparam logic signed [PWR_W-1:0] PWR_TURN = PWR_W'(70);
	localparam logic signed [PWR_W-1:0] PWR_BACK = -PWR_W'(70);
	localparam logic signed [PWR_W-1:0] PWR_CHK  = PWR_W'(50);

	typedef enum logic [2:0] {
		MODE_FWD        = 3'd0,
		MODE_LEFT       = 3'd1,
		MODE_CHECK      = 3'd2,
		MODE_RIGHT      = 3'd3,
		MODE_TURN90     = 3'd4,
		MODE_TURNAROUND = 3'd5
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TURN_ANGLE       = 2'd0,
		REG_TURNAROUND_ANGLE = 2'd1,
		REG_PERIOD           = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic outer_left;
		logic inner_left;
		logic middle;
		logic inner_right;
		logic outer_right;
		logic park;
	} ir_t;

	typedef struct packed {
		ir_t  ir;
		logic turn_done;
		logic turnaround_done;
	} fsm_in_t;

	typedef struct packed {
		mode_t                   next_mode;
		logic                    clear_heading;
		logic signed [PWR_W-1:0] left_power;
		logic signed [PWR_W-1:0] right_power;
	} fsm_out_t;

	// heading threshold in 1/16e6 degree units
	function automatic logic [THR_W-1:0] angle_thr(input logic [ANGLE_W-1:0] deg);
		angle_thr = THR_W'(deg) * HEADING_PER_DEG;
	endfunction

endpackage
`default_nettype wire

>>> sv/lfts_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfts channel interfaces
// Valid/ready channels for sensor items, result items and register writes.
// ----------------------------------------------------------------------------
interface lfts_in_if;
	logic               valid;
	logic               ready;
	logic               ir_outer_left;
	logic               ir_inner_left;
	logic               ir_middle;
	logic               ir_inner_right;
	logic               ir_outer_right;
	logic               ir_park;
	logic signed [15:0] yaw_rate;
	logic [31:0]        time_us;

	modport source (output valid, ir_outer_left, ir_inner_left, ir_middle, ir_inner_right,
		ir_outer_right, ir_park, yaw_rate, time_us, input ready);
	modport sink (input valid, ir_outer_left, ir_inner_left, ir_middle, ir_inner_right,
		ir_outer_right, ir_park, yaw_rate, time_us, output ready);
endinterface

interface lfts_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] left_power;
	logic signed [7:0] right_power;
	logic [2:0]        next_mode;

	modport source (output valid, left_power, right_power, next_mode, input ready);
	modport sink (input valid, left_power, right_power, next_mode, output ready);
endinterface

interface lfts_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [19:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

>>> sv/lfts_mode_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfts_mode_fsm
// Six-mode drive machine: motor powers of the current mode and next mode.
// ----------------------------------------------------------------------------
module lfts_mode_fsm
	import lfts_pkg::*;
(
	input  mode_t    mode,
	input  fsm_in_t  fin,
	output fsm_out_t fout
);

	mode_t next_mode;
	logic  clear_heading;
	logic  ol, il, mid, irr, orr, pk;

	assign ol  = fin.ir.outer_left;
	assign il  = fin.ir.inner_left;
	assign mid = fin.ir.middle;
	assign irr = fin.ir.inner_right;
	assign orr = fin.ir.outer_right;
	assign pk  = fin.ir.park;

	// next mode; later tests win
	always_comb begin
		next_mode     = mode;
		clear_heading = 1'b0;
		case (mode)
			MODE_LEFT: begin
				if (!ol && !il && mid && !irr && !orr) begin
					next_mode     = MODE_FWD;
					clear_heading = 1'b1;
				end
			end
			MODE_RIGHT: begin
				if (mid) begin
					next_mode     = MODE_FWD;
					clear_heading = 1'b1;
				end
			end
			MODE_TURN90: begin
				if (fin.turn_done) begin
					next_mode     = MODE_CHECK;
					clear_heading = 1'b1;
				end
			end
			MODE_TURNAROUND: begin
				if (fin.turnaround_done) begin
					next_mode     = MODE_CHECK;
					clear_heading = 1'b1;
				end
			end
			MODE_CHECK: begin
				if (mid) next_mode = MODE_FWD;
				if (il)  next_mode = MODE_RIGHT;
				if (irr) next_mode = MODE_LEFT;
			end
			default: begin
				next_mode = MODE_FWD;
				if (!il && !mid && irr && !pk) next_mode = MODE_LEFT;
				if (il && !mid && !irr && !pk) next_mode = MODE_RIGHT;
				if (ol && il && mid && irr && orr && !pk) next_mode = MODE_TURN90;
				if (!ol && !il && !mid && !irr && !orr && !pk) next_mode = MODE_TURNAROUND;
			end
		endcase
	end

	// motor powers of the current mode
	always_comb begin
		fout.next_mode     = next_mode;
		fout.clear_heading = clear_heading;
		case (mode)
			MODE_LEFT: begin
				fout.left_power  = PWR_FWD;
				fout.right_power = PWR_ZERO;
			end
			MODE_RIGHT: begin
				fout.left_power  = PWR_ZERO;
				fout.right_power = PWR_FWD;
			end
			MODE_TURN90: begin
				fout.left_power  = PWR_ZERO;
				fout.right_power = PWR_TURN;
			end
			MODE_TURNAROUND: begin
				fout.left_power  = PWR_BACK;
				fout.right_power = PWR_TURN;
			end
			MODE_CHECK: begin
				fout.left_power  = PWR_CHK;
				fout.right_power = PWR_CHK;
			end
			default: begin
				fout.left_power  = PWR_FWD;
				fout.right_power = PWR_FWD;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/line_follower_turn_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_follower_turn_sequencer
// Line-follower drive mode sequencer with gyro heading integration.
// ----------------------------------------------------------------------------
// Usage:
//   item_in    - one control tick per item: five line bits, the park bit,
//                a signed yaw rate (1/16 deg/s) and the microsecond time.
//   result_out - one item per tick: motor powers of the mode the tick ran in
//                and the mode that follows it.
//   cfg        - register writes (0 turn angle, 1 turn-around angle,
//                2 integration period); always ready, write only while idle.
// Timing:
//   An accepted item enters the input register together with yaw * period,
//   formed by the one multiplier. When the result slot is free, the mode
//   machine, the saturating heading add and the dwell compare update the
//   state and load the result register. One item per cycle is sustained
//   while the result side does not stall, since each tick's state is final
//   when the next tick leaves the input register.
// Reset: forward mode, dwell, heading and last integration time zero,
//   registers at their defaults; both pipeline stages empty.
// Stall: a held result keeps its value; the input register still takes one
//   more item, then item_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module line_follower_turn_sequencer
	import lfts_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	lfts_in_if.sink      item_in,
	lfts_out_if.source   result_out,
	lfts_cfg_if.sink     cfg
);

	// configuration
	logic [THR_W-1:0]    turn_thr_q;
	logic [THR_W-1:0]    turnaround_thr_q;
	logic [PERIOD_W-1:0] period_q;

	// input stage
	logic                      valid_s1;
	ir_t                       ir_s1;
	logic signed [PROD_W-1:0]  step_s1;
	logic [TIME_W-1:0]         time_s1;

	// result stage
	logic                      valid_s2;
	logic signed [PWR_W-1:0]   left_power_s2;
	logic signed [PWR_W-1:0]   right_power_s2;
	mode_t                     next_mode_s2;

	// tick state
	mode_t                     mode_q;
	logic                      pending_q;
	logic [TIME_W-1:0]         last_time_q;
	logic signed [HEAD_W-1:0]  heading_q;

	logic                      accept;
	logic                      adv;
	logic signed [PROD_W:0]    prod_full;
	fsm_in_t                   fin;
	fsm_out_t                  fout;
	logic signed [HEAD_W-1:0]  head_base;
	logic signed [HEAD_W:0]    head_sum;
	logic signed [HEAD_W-1:0]  head_nx;
	logic [TIME_W-1:0]         elapsed;

	// handshakes: the input register moves on whenever the result slot frees
	assign adv          = valid_s1 && (!valid_s2 || result_out.ready);
	assign item_in.ready = !valid_s1 || adv;
	assign accept       = item_in.valid && item_in.ready;
	assign cfg.ready    = 1'b1;

	// yaw * period, registered before the heading add
	assign prod_full = item_in.yaw_rate * $signed({1'b0, period_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_thr_q       <= angle_thr(TURN_ANGLE_RST);
			turnaround_thr_q <= angle_thr(TURNAROUND_ANGLE_RST);
			period_q         <= PERIOD_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.reg_index))
				REG_TURN_ANGLE:       turn_thr_q <= angle_thr(cfg.wdata[ANGLE_W-1:0]);
				REG_TURNAROUND_ANGLE: turnaround_thr_q <= angle_thr(cfg.wdata[ANGLE_W-1:0]);
				REG_PERIOD:           period_q <= cfg.wdata[PERIOD_W-1:0];
				default:              ; // drop writes beyond the register list
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ir_s1.outer_left  <= item_in.ir_outer_left;
			ir_s1.inner_left  <= item_in.ir_inner_left;
			ir_s1.middle      <= item_in.ir_middle;
			ir_s1.inner_right <= item_in.ir_inner_right;
			ir_s1.outer_right <= item_in.ir_outer_right;
			ir_s1.park        <= item_in.ir_park;
			step_s1           <= prod_full[PROD_W-1:0];
			time_s1           <= item_in.time_us;
		end
	end

	// mode machine on the current mode and heading
	always_comb begin
		fin.ir              = ir_s1;
		fin.turn_done       = heading_q >= $signed({{(HEAD_W-THR_W){1'b0}}, turn_thr_q});
		fin.turnaround_done = heading_q >= $signed({{(HEAD_W-THR_W){1'b0}}, turnaround_thr_q});
	end

	lfts_mode_fsm u_fsm (
		.mode (mode_q),
		.fin  (fin),
		.fout (fout)
	);

	// heading: clear by the mode machine first, then the saturating step
	always_comb begin
		head_base = fout.clear_heading ? '0 : heading_q;
		head_sum  = {head_base[HEAD_W-1], head_base}
			+ {{(HEAD_W+1-PROD_W){step_s1[PROD_W-1]}}, step_s1};
		if (head_sum[HEAD_W] != head_sum[HEAD_W-1]) begin
			// overflow: clamp to the limit on the side of the true sum
			head_nx = head_sum[HEAD_W] ? {1'b1, {(HEAD_W-1){1'b0}}}
				: {1'b0, {(HEAD_W-1){1'b1}}};
		end else begin
			head_nx = head_sum[HEAD_W-1:0];
		end
	end

	assign elapsed = time_s1 - last_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_FWD;
			pending_q   <= 1'b0;
			last_time_q <= '0;
			heading_q   <= '0;
		end else if (adv) begin
			mode_q <= fout.next_mode;
			if (pending_q) begin
				heading_q   <= head_nx;
				last_time_q <= time_s1;
				pending_q   <= 1'b0;
			end else begin
				heading_q <= head_base;
				if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_q}) pending_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_power_s2  <= fout.left_power;
			right_power_s2 <= fout.right_power;
			next_mode_s2   <= fout.next_mode;
		end
	end

	assign result_out.valid       = valid_s2;
	assign result_out.left_power  = left_power_s2;
	assign result_out.right_power = right_power_s2;
	assign result_out.next_mode   = next_mode_s2;

endmodule
`default_nettype wire

>>> sv/lfts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfts_checker
// Port-level checks of the turn sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lfts_checker
	import lfts_pkg::*;
(
	input wire             clk,
	input wire             arst_n,
	input wire             in_valid,
	input wire             in_ready,
	input wire             out_valid,
	input wire             out_ready,
	input wire signed [7:0] left_power,
	input wire signed [7:0] right_power,
	input wire [2:0]       next_mode
);

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_power)
			&& $stable(right_power) && $stable(next_mode))
		else $error("result changed while stalled");

	// every accepted item is followed by a valid result item
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted item produced no result");

	// with the result slot empty the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

	// left mode leaves only for forward
	a_left_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && left_power == PWR_FWD && right_power == PWR_ZERO
			|-> next_mode == MODE_LEFT || next_mode == MODE_FWD)
		else $error("illegal exit from left mode");

	// turn-around mode leaves only for check
	a_turn_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && left_power == PWR_BACK && right_power == PWR_TURN
			|-> next_mode == MODE_TURNAROUND || next_mode == MODE_CHECK)
		else $error("illegal exit from turn-around mode");

endmodule

bind line_follower_turn_sequencer lfts_checker u_lfts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item_in.valid),
	.in_ready    (item_in.ready),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.left_power  (result_out.left_power),
	.right_power (result_out.right_power),
	.next_mode   (result_out.next_mode)
);
`default_nettype wire

>>> tb/sv/line_follower_turn_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follower_turn_sequencer_tb
// Self-checking bench: a clocked driver feeds control ticks from a queue, an
// in-bench model of the mode machine and heading integrator predicts each
// result, and a clocked monitor compares every result field by field. The
// run steps through several register settings and idling profiles.
// ----------------------------------------------------------------------------
module line_follower_turn_sequencer_tb
	import lfts_pkg::*;
();

	// Motor powers per mode, heading scale and heading limits
	localparam logic signed [7:0] P_ZERO = 8'sd0;
	localparam logic signed [7:0] P_FWD  = 8'sd60;
	localparam logic signed [7:0] P_TURN = 8'sd70;
	localparam logic signed [7:0] P_BACK = -8'sd70;
	localparam logic signed [7:0] P_CHK  = 8'sd50;
	localparam longint DEG_SCALE   = 64'sd16000000;
	localparam longint HEADING_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint HEADING_MIN = -HEADING_MAX - 64'sd1;
	localparam int     HOLD_LEN    = 300;

	typedef struct {
		ir_t                ir;
		logic signed [15:0] yaw;
		logic [31:0]        time_us;
	} tick_t;

	typedef struct {
		logic signed [7:0] left_power;
		logic signed [7:0] right_power;
		logic [2:0]        next_mode;
	} drive_cmd_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lfts_in_if  tick_if ();
	lfts_out_if cmd_if ();
	lfts_cfg_if reg_if ();

	line_follower_turn_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (tick_if),
		.result_out (cmd_if),
		.cfg        (reg_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Model state and register copies, at their reset values
	mode_t       seq_mode       = MODE_FWD;
	logic        integ_pending  = 1'b0;
	logic [31:0] last_integ_us  = '0;
	longint      heading        = 0;
	logic [8:0]  turn_deg       = 9'd72;
	logic [8:0]  turnaround_deg = 9'd140;
	logic [19:0] period_us      = 20'd10000;

	tick_t      tick_queue[$];     // ticks waiting for the driver
	drive_cmd_t expected_cmds[$];  // predicted results, oldest first
	tick_t      tick_on_wire;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_armed = 1'b0;
	int          hold_cycles = 0;
	logic        rx_held;
	int          fail_count = 0;
	int          ticks_accepted = 0;
	int          cmds_checked = 0;
	int          settings_run = 1;
	logic [5:0]  mode_seen = '0;
	logic [31:0] gen_time = '0;
	logic [19:0] gen_period = 20'd10000;

	function automatic longint angle_threshold(input logic [8:0] deg);
		return longint'(deg) * DEG_SCALE;
	endfunction

	// Run one tick through the model: powers of the current mode, the next
	// mode (later tests win), then the dwell/integrate pair.
	function automatic drive_cmd_t advance_sequencer(input tick_t t);
		drive_cmd_t  cmd;
		mode_t       nxt;
		logic [31:0] elapsed;
		longint      step;
		nxt = seq_mode;
		case (seq_mode)
			MODE_LEFT: begin
				cmd.left_power  = P_FWD;
				cmd.right_power = P_ZERO;
				if (!t.ir.outer_left && !t.ir.inner_left && t.ir.middle &&
						!t.ir.inner_right && !t.ir.outer_right) begin
					nxt = MODE_FWD;
					heading = 0;
				end
			end
			MODE_RIGHT: begin
				cmd.left_power  = P_ZERO;
				cmd.right_power = P_FWD;
				if (t.ir.middle) begin
					nxt = MODE_FWD;
					heading = 0;
				end
			end
			MODE_TURN90: begin
				cmd.left_power  = P_ZERO;
				cmd.right_power = P_TURN;
				if (heading >= angle_threshold(turn_deg)) begin
					nxt = MODE_CHECK;
					heading = 0;
				end
			end
			MODE_TURNAROUND: begin
				cmd.left_power  = P_BACK;
				cmd.right_power = P_TURN;
				if (heading >= angle_threshold(turnaround_deg)) begin
					nxt = MODE_CHECK;
					heading = 0;
				end
			end
			MODE_CHECK: begin
				cmd.left_power  = P_CHK;
				cmd.right_power = P_CHK;
				if (t.ir.middle)
					nxt = MODE_FWD;
				if (t.ir.inner_left)
					nxt = MODE_RIGHT;
				if (t.ir.inner_right)
					nxt = MODE_LEFT;
			end
			default: begin
				cmd.left_power  = P_FWD;
				cmd.right_power = P_FWD;
				nxt = MODE_FWD;
				if (!t.ir.inner_left && !t.ir.middle && t.ir.inner_right && !t.ir.park)
					nxt = MODE_LEFT;
				if (t.ir.inner_left && !t.ir.middle && !t.ir.inner_right && !t.ir.park)
					nxt = MODE_RIGHT;
				if (t.ir == 6'b111110)
					nxt = MODE_TURN90;
				if (t.ir == 6'b000000)
					nxt = MODE_TURNAROUND;
			end
		endcase
		seq_mode = nxt;

		if (!integ_pending) begin
			// elapsed time wraps modulo 2^32
			elapsed = t.time_us - last_integ_us;
			if (elapsed >= 32'(period_us))
				integ_pending = 1'b1;
		end else begin
			step = longint'(t.yaw) * longint'(period_us);
			if (step > 0 && heading > HEADING_MAX - step)
				heading = HEADING_MAX;
			else if (step < 0 && heading < HEADING_MIN - step)
				heading = HEADING_MIN;
			else
				heading = heading + step;
			integ_pending = 1'b0;
			last_integ_us = t.time_us;
		end
		cmd.next_mode = nxt;
		return cmd;
	endfunction

	// Driver: on acceptance predict the result, then offer the next tick
	// unless the sender idles this cycle. Hold the item while it is stalled.
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_if.valid <= 1'b0;
		end else begin
			if (tick_if.valid && tick_if.ready) begin
				expected_cmds.push_back(advance_sequencer(tick_on_wire));
				ticks_accepted++;
			end
			if (!tick_if.valid || tick_if.ready) begin
				if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					tick_on_wire = tick_queue.pop_front();
					tick_if.ir_outer_left  <= tick_on_wire.ir.outer_left;
					tick_if.ir_inner_left  <= tick_on_wire.ir.inner_left;
					tick_if.ir_middle      <= tick_on_wire.ir.middle;
					tick_if.ir_inner_right <= tick_on_wire.ir.inner_right;
					tick_if.ir_outer_right <= tick_on_wire.ir.outer_right;
					tick_if.ir_park        <= tick_on_wire.ir.park;
					tick_if.yaw_rate       <= tick_on_wire.yaw;
					tick_if.time_us        <= tick_on_wire.time_us;
					tick_if.valid          <= 1'b1;
				end else begin
					tick_if.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off: count cycles from arming and hold ready low
	// until the count runs out, so the pipeline fills and stalls its input.
	always @(posedge clk) begin
		if (!hold_armed)
			hold_cycles <= 0;
		else if (hold_cycles < HOLD_LEN)
			hold_cycles <= hold_cycles + 1;
	end
	assign rx_held = hold_armed && (hold_cycles < HOLD_LEN);

	// Monitor: check each accepted result against the oldest prediction.
	always @(posedge clk) begin
		drive_cmd_t want;
		if (!arst_n) begin
			cmd_if.ready <= 1'b0;
		end else begin
			if (cmd_if.valid && cmd_if.ready) begin
				if (expected_cmds.size() == 0) begin
					$error("result item with no tick pending: left %0d right %0d mode %0d",
						cmd_if.left_power, cmd_if.right_power, cmd_if.next_mode);
					fail_count++;
				end else begin
					want = expected_cmds.pop_front();
					cmds_checked++;
					if (cmd_if.left_power !== want.left_power) begin
						$error("left_power: expected %0d, got %0d",
							want.left_power, cmd_if.left_power);
						fail_count++;
					end
					if (cmd_if.right_power !== want.right_power) begin
						$error("right_power: expected %0d, got %0d",
							want.right_power, cmd_if.right_power);
						fail_count++;
					end
					if (cmd_if.next_mode !== want.next_mode) begin
						$error("next_mode: expected %0d, got %0d",
							want.next_mode, cmd_if.next_mode);
						fail_count++;
					end
					if (want.next_mode < 6)
						mode_seen[want.next_mode] = 1'b1;
				end
			end
			cmd_if.ready <= !rx_held && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic coin();
		return 1'($urandom_range(1));
	endfunction

	// Next tick time: mostly about one period later, sometimes unchanged,
	// sometimes a jump anywhere so the elapsed time wraps.
	function automatic logic [31:0] next_time();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			gen_time = $urandom();
		else if (r >= 15)
			gen_time = gen_time + $urandom_range(2 * gen_period + 2, 0);
		return gen_time;
	endfunction

	function automatic void push_at(input ir_t ir, input logic signed [15:0] yaw,
			input logic [31:0] t_us);
		tick_t t;
		t.ir = ir;
		t.yaw = yaw;
		t.time_us = t_us;
		gen_time = t_us;
		tick_queue.push_back(t);
	endfunction

	function automatic void push_tick(input ir_t ir, input logic signed [15:0] yaw);
		push_at(ir, yaw, next_time());
	endfunction

	function automatic logic signed [15:0] small_yaw();
		return 16'($signed($urandom_range(4000)) - 2000);
	endfunction

	function automatic logic signed [15:0] turn_yaw();
		return 16'($urandom_range(32767, 4000));
	endfunction

	// Random well-formed sequences with random content, plus some noise.
	// Return the number of ticks queued.
	function automatic int queue_sequence();
		int n;
		int k;
		n = 0;
		case ($urandom_range(99) / 15)
			0: begin
				// line following with wobble
				k = $urandom_range(8, 1);
				repeat (k) push_tick(ir_t'({coin() & coin(), coin() & coin(), 1'b1,
					coin() & coin(), coin() & coin(), coin() & coin()}), small_yaw());
				n = k;
			end
			1: begin
				// enter left, drift, recover on the middle sensor
				push_tick(ir_t'({coin(), 2'b00, 1'b1, coin(), 1'b0}), small_yaw());
				k = $urandom_range(4, 0);
				repeat (k) push_tick(ir_t'(6'($urandom())), small_yaw());
				push_tick(ir_t'({5'b00100, coin()}), small_yaw());
				n = k + 2;
			end
			2: begin
				// enter right, drift, recover on the middle sensor
				push_tick(ir_t'({coin(), 1'b1, 2'b00, coin(), 1'b0}), small_yaw());
				k = $urandom_range(4, 0);
				repeat (k) push_tick(ir_t'(6'($urandom()) & 6'b110111), small_yaw());
				push_tick(ir_t'({coin(), coin(), 1'b1, coin(), coin(), coin()}), small_yaw());
				n = k + 2;
			end
			3, 4: begin
				// cross or line end, turn on the gyro, then look for the line
				if (coin())
					push_tick(ir_t'(6'b111110), small_yaw());
				else
					push_tick(ir_t'(6'b000000), small_yaw());
				k = $urandom_range(30, 4);
				repeat (k) push_tick(ir_t'(6'($urandom())), turn_yaw());
				push_tick(ir_t'({coin(), coin(), coin(), coin(), coin(), coin()}), small_yaw());
				n = k + 2;
			end
			default: begin
				// noise over the full range of the sensor bits and the yaw rate
				k = $urandom_range(6, 1);
				repeat (k) push_tick(ir_t'(6'($urandom())), 16'($urandom()));
				n = k;
			end
		endcase
		return n;
	endfunction

	task automatic queue_random(input int count);
		int queued;
		queued = 0;
		@(negedge clk);
		while (queued < count)
			queued += queue_sequence();
	endtask

	// Wait until no tick is queued or on the wire and every result is in.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (tick_queue.size() != 0 || tick_if.valid || expected_cmds.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [19:0] value);
		@(posedge clk);
		reg_if.valid     <= 1'b1;
		reg_if.reg_index <= idx;
		reg_if.wdata     <= value;
		@(posedge clk);
		while (!reg_if.ready)
			@(posedge clk);
		reg_if.valid <= 1'b0;
		case (idx)
			REG_TURN_ANGLE:       turn_deg = value[8:0];
			REG_TURNAROUND_ANGLE: turnaround_deg = value[8:0];
			REG_PERIOD: begin
				period_us  = value;
				gen_period = value;
			end
			default: ;
		endcase
	endtask

	// Drain, load a new register setting and idling profile.
	task automatic new_setting(input int ang, input int back_ang, input int per,
			input int send_pct, input int recv_pct);
		wait_idle();
		write_reg(REG_TURN_ANGLE, 20'(ang));
		write_reg(REG_TURNAROUND_ANGLE, 20'(back_ang));
		write_reg(REG_PERIOD, 20'(per));
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		settings_run++;
	endtask

	initial begin
		tick_if.valid          = 1'b0;
		tick_if.ir_outer_left  = 1'b0;
		tick_if.ir_inner_left  = 1'b0;
		tick_if.ir_middle      = 1'b0;
		tick_if.ir_inner_right = 1'b0;
		tick_if.ir_outer_right = 1'b0;
		tick_if.ir_park        = 1'b0;
		tick_if.yaw_rate       = '0;
		tick_if.time_us        = '0;
		cmd_if.ready           = 1'b0;
		reg_if.valid           = 1'b0;
		reg_if.reg_index       = REG_TURN_ANGLE;
		reg_if.wdata           = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed ticks on the reset register values, no idling
		@(negedge clk);
		push_at(ir_t'(6'b001000), 16'sd0, 32'd0);             // stay forward
		push_at(ir_t'(6'b000100), 16'sd32767, 32'hFFFF_FFFF); // forward to left
		push_at(ir_t'(6'b001000), -16'sd32768, 32'd5);        // back to forward, wrapped
		push_at(ir_t'(6'b010000), 16'sd0, 32'd10005);         // forward to right
		push_at(ir_t'(6'b001000), 16'sd0, 32'd20005);         // right back to forward
		push_at(ir_t'(6'b000001), 16'sd0, 32'd20006);         // park blocks turn-around
		push_at(ir_t'(6'b111111), 16'sd0, 32'd20007);         // park blocks turn90
		push_at(ir_t'(6'b111110), 16'sd0, 32'd20008);         // enter turn90
		for (int i = 1; i <= 10; i++)
			push_at(ir_t'(6'b000000), 16'sd32767, 32'd20008 + 32'(i) * 32'd10000);
		push_at(ir_t'(6'b011100), 16'sd0, 32'd130008);        // check: right sensor wins
		push_at(ir_t'(6'b001000), 16'sd0, 32'd130009);        // left back to forward
		push_at(ir_t'(6'b000000), -16'sd1, 32'd140009);       // enter turn-around
		push_at(ir_t'(6'b101011), 16'sd32767, 32'd150009);
		push_at(ir_t'(6'b010100), 16'sd32767, 32'd160009);
		queue_random(300);

		// Zero angles and zero period; sender idles heavily
		new_setting(0, 0, 0, 75, 0);
		queue_random(300);

		// Angles of 360 and a period of 1000000; receiver stalls heavily
		new_setting(360, 360, 1000000, 0, 75);
		queue_random(300);

		// Shortest nonzero period; light idling on both sides
		new_setting(1, 359, 1, 11, 11);
		queue_random(250);

		// Long receiver hold-off with the sender at full rate, then a pause
		// until all results are in, then full rate again
		new_setting(20, 45, 5000, 0, 0);
		hold_armed = 1'b1;
		queue_random(250);
		wait_idle();
		hold_armed = 1'b0;
		queue_random(100);

		// Random settings
		new_setting($urandom_range(360), $urandom_range(360),
			$urandom_range(60000, 1000), 11, 11);
		queue_random(300);
		new_setting($urandom_range(90), $urandom_range(90),
			$urandom_range(1000000, 1), 75, 0);
		queue_random(200);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Ran %0d ticks over %0d register settings, %0d results checked.",
			ticks_accepted, settings_run, cmds_checked);
		$display("Modes reached (bit per mode code, 5..0): %b", mode_seen);
		if (fail_count == 0 && expected_cmds.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#10_000_000;
		$display("Timeout with %0d results outstanding", expected_cmds.size());
		$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
sv/lfts_pkg.sv
sv/lfts_if.sv
sv/lfts_mode_fsm.sv
sv/line_follower_turn_sequencer.sv
sv/lfts_checker.sv
tb/sv/line_follower_turn_sequencer_tb.sv
